/* rtl/kedq_pkg.sv */
// Shared constants, types and codes of the keyed exclusive dispatch queue.
package kedq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_WORKERS = 4;
   localparam int KEY_BITS = 32;
   localparam int TAG_BITS = 8;

   localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QF_W = $clog2(QUEUE_DEPTH + 1);
   localparam int RF_W = $clog2(MAX_WORKERS + 1);
   localparam int ENTRY_W = TAG_BITS + KEY_BITS;
   localparam int CNT_W = 32;
   localparam int CAP_W = 5;
   localparam int WLIM_W = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [1:0] {
      OP_SUBMIT   = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_COMPLETE = 2'd2,
      OP_CLOSE    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_ACCEPTED  = 4'd0,
      ST_SATURATED = 4'd1,
      ST_CLOSED    = 4'd2,
      ST_INVALID   = 4'd3,
      ST_DISPATCH  = 4'd4,
      ST_BLOCKED   = 4'd5,
      ST_EMPTY     = 4'd6,
      ST_DRAINED   = 4'd7,
      ST_BUSY      = 4'd8,
      ST_COMPLETED = 4'd9,
      ST_COMP_ERR  = 4'd10,
      ST_CLOSE_ACK = 4'd11
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAPACITY = 1'd0,
      REG_WORKERS  = 1'd1
   } reg_idx_type;

   typedef struct packed {
      logic push;
      logic pop;
   } run_ctl_type;

   typedef struct packed {
      logic            held;
      logic            hit;
      logic [RF_W-1:0] fill;
   } run_sts_type;

endpackage

/* rtl/kedq_if.sv */
// Valid/ready channel interfaces for requests, responses and register writes.
interface kedq_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    operation;
   logic                          job_valid;
   logic [kedq_pkg::TAG_BITS-1:0] job_tag;
   logic [kedq_pkg::KEY_BITS-1:0] lock_key;
   modport source (output valid, operation, job_valid, job_tag, lock_key, input ready);
   modport sink (input valid, operation, job_valid, job_tag, lock_key, output ready);
endinterface

interface kedq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [3:0]                    status;
   logic [kedq_pkg::TAG_BITS-1:0] job_tag_res;
   logic [kedq_pkg::KEY_BITS-1:0] job_key;
   logic [kedq_pkg::RF_W-1:0]     active_count;
   logic [kedq_pkg::QF_W-1:0]     backlog_count;
   logic [kedq_pkg::QF_W-1:0]     owned_count;
   logic [kedq_pkg::RF_W-1:0]     peak_active;
   logic [kedq_pkg::QF_W-1:0]     peak_backlog;
   logic [kedq_pkg::QF_W-1:0]     peak_owned;
   logic [kedq_pkg::CNT_W-1:0]    accepted_total;
   logic [kedq_pkg::CNT_W-1:0]    saturated_total;
   logic [kedq_pkg::CNT_W-1:0]    closed_total;
   modport source (output valid, status, job_tag_res, job_key, active_count, backlog_count,
      owned_count, peak_active, peak_backlog, peak_owned, accepted_total, saturated_total,
      closed_total, input ready);
   modport sink (input valid, status, job_tag_res, job_key, active_count, backlog_count,
      owned_count, peak_active, peak_backlog, peak_owned, accepted_total, saturated_total,
      closed_total, output ready);
endinterface

interface kedq_csr_if;
   logic                            valid;
   logic                            ready;
   logic [kedq_pkg::CSR_IDX_W-1:0]  index;
   logic [kedq_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/kedq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kedq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/kedq_run.sv */
// Set of keys held by running jobs, with hold check, completion match and removal.
module kedq_run (
   input  logic                          clock,
   input  logic                          reset,
   input  kedq_pkg::run_ctl_type         ctl,
   input  logic [kedq_pkg::KEY_BITS-1:0] chk_key,
   input  logic [kedq_pkg::KEY_BITS-1:0] cmp_key,
   output kedq_pkg::run_sts_type         sts
);

   logic [kedq_pkg::KEY_BITS-1:0] key_ff [kedq_pkg::MAX_WORKERS];
   logic [kedq_pkg::KEY_BITS-1:0] key_in [kedq_pkg::MAX_WORKERS];
   logic [kedq_pkg::RF_W-1:0]     fill_ff;
   logic [kedq_pkg::RF_W-1:0]     fill_in;
   logic [kedq_pkg::RF_W-1:0]     hit_idx;
   logic                          held;
   logic                          hit;

   always_comb begin
      held = 1'b0;
      hit = 1'b0;
      hit_idx = '0;
      for (int i = kedq_pkg::MAX_WORKERS - 1; i >= 0; i--) begin
         if (kedq_pkg::RF_W'(i) < fill_ff && key_ff[i] == cmp_key) begin
            hit = 1'b1;
            hit_idx = kedq_pkg::RF_W'(i);
         end
         if (kedq_pkg::RF_W'(i) < fill_ff && key_ff[i] == chk_key) begin
            held = 1'b1;
         end
      end
      if (chk_key == '0) begin
         held = 1'b0;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      for (int i = 0; i < kedq_pkg::MAX_WORKERS; i++) begin
         key_in[i] = key_ff[i];
         if (ctl.push && kedq_pkg::RF_W'(i) == fill_ff) begin
            key_in[i] = chk_key;
         end
      end
      for (int i = 0; i < kedq_pkg::MAX_WORKERS - 1; i++) begin
         if (ctl.pop && hit && kedq_pkg::RF_W'(i) >= hit_idx) begin
            key_in[i] = key_ff[i + 1];
         end
      end
      if (ctl.push) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop && hit) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      for (int i = 0; i < kedq_pkg::MAX_WORKERS; i++) begin
         key_ff[i] <= key_in[i];
      end
   end

   assign sts.held = held;
   assign sts.hit = hit;
   assign sts.fill = fill_ff;

endmodule

/* rtl/keyed_exclusive_dispatch_queue_top.sv */
// Top level of the keyed exclusive dispatch queue: command sequencer, counters and queue memory.
// Submit, completion and close beats pass through the execute state and load the response
// register in the done state; the next request beat is then accepted back in the idle state.
// A dispatch reads the queue memory one entry a cycle, oldest first, until it finds a job
// whose key no running job holds, then moves every younger entry down one place, again one
// entry a cycle through the memory's single read and write port; if none is found, it reports
// blocked. A response that is not taken holds the sequencer before it loads the next one.
// A new request beat is taken while the previous response still waits.
module keyed_exclusive_dispatch_queue_top (
   input  logic       clock,
   input  logic       reset,
   kedq_req_if.sink   req_ch,
   kedq_rsp_if.source rsp_ch,
   kedq_csr_if.sink   csr_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type                       state_ff, state_in;
   kedq_pkg::op_type                op_ff, op_in;
   logic                            vld_ff, vld_in;
   logic [kedq_pkg::TAG_BITS-1:0]   tag_ff, tag_in;
   logic [kedq_pkg::KEY_BITS-1:0]   key_ff, key_in;
   logic [kedq_pkg::QF_W-1:0]       qfill_ff, qfill_in;
   logic [kedq_pkg::QF_W-1:0]       owned_ff, owned_in;
   logic [kedq_pkg::RF_W-1:0]       pk_run_ff, pk_run_in;
   logic [kedq_pkg::QF_W-1:0]       pk_q_ff, pk_q_in;
   logic [kedq_pkg::QF_W-1:0]       pk_own_ff, pk_own_in;
   logic [kedq_pkg::CNT_W-1:0]      acc_ff, acc_in;
   logic [kedq_pkg::CNT_W-1:0]      sat_ff, sat_in;
   logic [kedq_pkg::CNT_W-1:0]      clo_ff, clo_in;
   logic                            admit_ff, admit_in;
   logic [kedq_pkg::CAP_W-1:0]      cap_ff, cap_in;
   logic [kedq_pkg::WLIM_W-1:0]     wlim_ff, wlim_in;
   logic [kedq_pkg::QA_W-1:0]       idx_ff, idx_in;
   kedq_pkg::status_type            res_st_ff, res_st_in;
   logic [kedq_pkg::TAG_BITS-1:0]   res_tag_ff, res_tag_in;
   logic [kedq_pkg::KEY_BITS-1:0]   res_key_ff, res_key_in;
   logic                            rsp_vld_ff, rsp_vld_in;
   kedq_pkg::status_type            rsp_st_ff, rsp_st_in;
   logic [kedq_pkg::TAG_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [kedq_pkg::KEY_BITS-1:0]   rsp_key_ff, rsp_key_in;
   logic [kedq_pkg::RF_W-1:0]       rsp_act_ff, rsp_act_in;
   logic [kedq_pkg::QF_W-1:0]       rsp_back_ff, rsp_back_in;
   logic [kedq_pkg::QF_W-1:0]       rsp_own_ff, rsp_own_in;
   logic [kedq_pkg::RF_W-1:0]       rsp_pk_run_ff, rsp_pk_run_in;
   logic [kedq_pkg::QF_W-1:0]       rsp_pk_q_ff, rsp_pk_q_in;
   logic [kedq_pkg::QF_W-1:0]       rsp_pk_own_ff, rsp_pk_own_in;
   logic [kedq_pkg::CNT_W-1:0]      rsp_acc_ff, rsp_acc_in;
   logic [kedq_pkg::CNT_W-1:0]      rsp_sat_ff, rsp_sat_in;
   logic [kedq_pkg::CNT_W-1:0]      rsp_clo_ff, rsp_clo_in;

   logic                            ram_we;
   logic [kedq_pkg::QA_W-1:0]       ram_waddr;
   logic [kedq_pkg::ENTRY_W-1:0]    ram_wdata;
   logic [kedq_pkg::QA_W-1:0]       ram_raddr;
   logic [kedq_pkg::ENTRY_W-1:0]    ram_rdata;
   logic [kedq_pkg::KEY_BITS-1:0]   rd_key;
   logic [kedq_pkg::TAG_BITS-1:0]   rd_tag;
   kedq_pkg::run_ctl_type           run_ctl;
   kedq_pkg::run_sts_type           run_sts;
   logic                            out_free;
   logic                            cap_full;
   logic                            workers_full;
   logic [kedq_pkg::QF_W-1:0]       nxt;
   logic [kedq_pkg::RF_W:0]         run_next;

   kedq_ram #(
      .WIDTH (kedq_pkg::ENTRY_W),
      .DEPTH (kedq_pkg::QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   kedq_run u_run (
      .clock   (clock),
      .reset   (reset),
      .ctl     (run_ctl),
      .chk_key (rd_key),
      .cmp_key (key_ff),
      .sts     (run_sts)
   );

   assign rd_key = ram_rdata[kedq_pkg::KEY_BITS-1:0];
   assign rd_tag = ram_rdata[kedq_pkg::ENTRY_W-1:kedq_pkg::KEY_BITS];
   assign out_free = !rsp_vld_ff || rsp_ch.ready;
   assign nxt = kedq_pkg::QF_W'(idx_ff) + 1'b1;
   assign run_next = {1'b0, run_sts.fill} + 1'b1;

   assign cap_full = ({{kedq_pkg::CAP_W{1'b0}}, owned_ff} >=
                      {{kedq_pkg::QF_W{1'b0}}, cap_ff})
                     || owned_ff >= kedq_pkg::QF_W'(kedq_pkg::QUEUE_DEPTH)
                     || qfill_ff >= kedq_pkg::QF_W'(kedq_pkg::QUEUE_DEPTH);
   assign workers_full = ({{kedq_pkg::WLIM_W{1'b0}}, run_sts.fill} >=
                          {{kedq_pkg::RF_W{1'b0}}, wlim_ff})
                         || run_sts.fill >= kedq_pkg::RF_W'(kedq_pkg::MAX_WORKERS);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      vld_in = vld_ff;
      tag_in = tag_ff;
      key_in = key_ff;
      qfill_in = qfill_ff;
      owned_in = owned_ff;
      pk_run_in = pk_run_ff;
      pk_q_in = pk_q_ff;
      pk_own_in = pk_own_ff;
      acc_in = acc_ff;
      sat_in = sat_ff;
      clo_in = clo_ff;
      admit_in = admit_ff;
      cap_in = cap_ff;
      wlim_in = wlim_ff;
      idx_in = idx_ff;
      res_st_in = res_st_ff;
      res_tag_in = res_tag_ff;
      res_key_in = res_key_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      rsp_st_in = rsp_st_ff;
      rsp_tag_in = rsp_tag_ff;
      rsp_key_in = rsp_key_ff;
      rsp_act_in = rsp_act_ff;
      rsp_back_in = rsp_back_ff;
      rsp_own_in = rsp_own_ff;
      rsp_pk_run_in = rsp_pk_run_ff;
      rsp_pk_q_in = rsp_pk_q_ff;
      rsp_pk_own_in = rsp_pk_own_ff;
      rsp_acc_in = rsp_acc_ff;
      rsp_sat_in = rsp_sat_ff;
      rsp_clo_in = rsp_clo_ff;
      ram_we = 1'b0;
      ram_waddr = qfill_ff[kedq_pkg::QA_W-1:0];
      ram_wdata = {tag_ff, key_ff};
      ram_raddr = idx_ff;
      run_ctl = '0;

      if (csr_ch.valid) begin
         unique case (kedq_pkg::reg_idx_type'(csr_ch.index))
            kedq_pkg::REG_CAPACITY: cap_in = csr_ch.data[kedq_pkg::CAP_W-1:0];
            kedq_pkg::REG_WORKERS:  wlim_in = csr_ch.data[kedq_pkg::WLIM_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in = kedq_pkg::op_type'(req_ch.operation);
               vld_in = req_ch.job_valid;
               tag_in = req_ch.job_tag;
               key_in = req_ch.lock_key;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_tag_in = '0;
            res_key_in = '0;
            state_in = S_DONE;
            unique case (op_ff)
               kedq_pkg::OP_SUBMIT: begin
                  if (!vld_ff) begin
                     res_st_in = kedq_pkg::ST_INVALID;
                  end else if (!admit_ff) begin
                     res_st_in = kedq_pkg::ST_CLOSED;
                     clo_in = (clo_ff == '1) ? clo_ff : clo_ff + 1'b1;
                  end else if (cap_full) begin
                     res_st_in = kedq_pkg::ST_SATURATED;
                     sat_in = (sat_ff == '1) ? sat_ff : sat_ff + 1'b1;
                  end else begin
                     res_st_in = kedq_pkg::ST_ACCEPTED;
                     ram_we = 1'b1;
                     qfill_in = qfill_ff + 1'b1;
                     owned_in = owned_ff + 1'b1;
                     acc_in = (acc_ff == '1) ? acc_ff : acc_ff + 1'b1;
                     if (owned_in > pk_own_ff) begin
                        pk_own_in = owned_in;
                     end
                     if (qfill_in > pk_q_ff) begin
                        pk_q_in = qfill_in;
                     end
                  end
               end
               kedq_pkg::OP_DISPATCH: begin
                  if (workers_full) begin
                     res_st_in = kedq_pkg::ST_BUSY;
                  end else if (qfill_ff == '0) begin
                     res_st_in = admit_ff ? kedq_pkg::ST_EMPTY : kedq_pkg::ST_DRAINED;
                  end else begin
                     ram_raddr = '0;
                     idx_in = '0;
                     state_in = S_SCAN;
                  end
               end
               kedq_pkg::OP_COMPLETE: begin
                  if (run_sts.hit) begin
                     run_ctl.pop = 1'b1;
                     res_st_in = kedq_pkg::ST_COMPLETED;
                     if (owned_ff != '0) begin
                        owned_in = owned_ff - 1'b1;
                     end
                  end else begin
                     res_st_in = kedq_pkg::ST_COMP_ERR;
                  end
               end
               kedq_pkg::OP_CLOSE: begin
                  admit_in = 1'b0;
                  res_st_in = kedq_pkg::ST_CLOSE_ACK;
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            if (!run_sts.held) begin
               run_ctl.push = 1'b1;
               res_st_in = kedq_pkg::ST_DISPATCH;
               res_tag_in = rd_tag;
               res_key_in = rd_key;
               if (run_next > {1'b0, pk_run_ff}) begin
                  pk_run_in = run_next[kedq_pkg::RF_W-1:0];
               end
               if (nxt < qfill_ff) begin
                  ram_raddr = nxt[kedq_pkg::QA_W-1:0];
                  idx_in = nxt[kedq_pkg::QA_W-1:0];
                  state_in = S_SHIFT;
               end else begin
                  qfill_in = qfill_ff - 1'b1;
                  state_in = S_DONE;
               end
            end else if (nxt < qfill_ff) begin
               ram_raddr = nxt[kedq_pkg::QA_W-1:0];
               idx_in = nxt[kedq_pkg::QA_W-1:0];
            end else begin
               res_st_in = kedq_pkg::ST_BLOCKED;
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            ram_we = 1'b1;
            ram_waddr = idx_ff - 1'b1;
            ram_wdata = ram_rdata;
            if (nxt < qfill_ff) begin
               ram_raddr = nxt[kedq_pkg::QA_W-1:0];
               idx_in = nxt[kedq_pkg::QA_W-1:0];
            end else begin
               qfill_in = qfill_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_st_in = res_st_ff;
               rsp_tag_in = res_tag_ff;
               rsp_key_in = res_key_ff;
               rsp_act_in = run_sts.fill;
               rsp_back_in = qfill_ff;
               rsp_own_in = owned_ff;
               rsp_pk_run_in = pk_run_ff;
               rsp_pk_q_in = pk_q_ff;
               rsp_pk_own_in = pk_own_ff;
               rsp_acc_in = acc_ff;
               rsp_sat_in = sat_ff;
               rsp_clo_in = clo_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         qfill_ff <= '0;
         owned_ff <= '0;
         pk_run_ff <= '0;
         pk_q_ff <= '0;
         pk_own_ff <= '0;
         acc_ff <= '0;
         sat_ff <= '0;
         clo_ff <= '0;
         admit_ff <= 1'b1;
         cap_ff <= kedq_pkg::CAP_W'(16);
         wlim_ff <= kedq_pkg::WLIM_W'(4);
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         qfill_ff <= qfill_in;
         owned_ff <= owned_in;
         pk_run_ff <= pk_run_in;
         pk_q_ff <= pk_q_in;
         pk_own_ff <= pk_own_in;
         acc_ff <= acc_in;
         sat_ff <= sat_in;
         clo_ff <= clo_in;
         admit_ff <= admit_in;
         cap_ff <= cap_in;
         wlim_ff <= wlim_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      op_ff <= op_in;
      vld_ff <= vld_in;
      tag_ff <= tag_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      res_st_ff <= res_st_in;
      res_tag_ff <= res_tag_in;
      res_key_ff <= res_key_in;
      rsp_st_ff <= rsp_st_in;
      rsp_tag_ff <= rsp_tag_in;
      rsp_key_ff <= rsp_key_in;
      rsp_act_ff <= rsp_act_in;
      rsp_back_ff <= rsp_back_in;
      rsp_own_ff <= rsp_own_in;
      rsp_pk_run_ff <= rsp_pk_run_in;
      rsp_pk_q_ff <= rsp_pk_q_in;
      rsp_pk_own_ff <= rsp_pk_own_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_clo_ff <= rsp_clo_in;
   end

   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.status = rsp_st_ff;
   assign rsp_ch.job_tag_res = rsp_tag_ff;
   assign rsp_ch.job_key = rsp_key_ff;
   assign rsp_ch.active_count = rsp_act_ff;
   assign rsp_ch.backlog_count = rsp_back_ff;
   assign rsp_ch.owned_count = rsp_own_ff;
   assign rsp_ch.peak_active = rsp_pk_run_ff;
   assign rsp_ch.peak_backlog = rsp_pk_q_ff;
   assign rsp_ch.peak_owned = rsp_pk_own_ff;
   assign rsp_ch.accepted_total = rsp_acc_ff;
   assign rsp_ch.saturated_total = rsp_sat_ff;
   assign rsp_ch.closed_total = rsp_clo_ff;

`ifndef SYNTHESIS
   // While younger entries move down, the dispatched job is already counted as running.
   a_owned_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_SHIFT |->
      {1'b0, owned_ff} == {1'b0, qfill_ff} + (kedq_pkg::QF_W + 1)'(run_sts.fill))
      else $error("Owned count differs from queued plus running jobs.");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qfill_ff <= kedq_pkg::QF_W'(kedq_pkg::QUEUE_DEPTH))
      else $error("Queue fill exceeds the queue depth.");
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_sts.fill <= kedq_pkg::RF_W'(kedq_pkg::MAX_WORKERS))
      else $error("Running fill exceeds the number of workers.");
   a_rsp_only_from_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_vld_ff && rsp_vld_in |-> state_ff == S_DONE)
      else $error("Response loaded outside the completion state.");
`endif

endmodule
